FILE: rtl/rtg_pkg.sv
package rtg_pkg;

    // Serial multiplier operand and product widths
    localparam int unsigned OPW = 33;
    localparam int unsigned PW  = 2 * OPW + 1;
    // Wide signed width used before saturation
    localparam int unsigned SW  = PW + 1;

    // CORDIC table length and step counter width
    localparam int unsigned TAB_LEN = 24;
    localparam int unsigned STEP_W  = 5;

    // Binary angle constants, full turn is 2^32
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
    // round(2^32 / (2*pi))
    localparam logic [31:0] INV_TWO_PI   = 32'd683565276;
    // CORDIC start value, Q2.30 inverse gain
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    // Mode codes; any other code behaves as hover
    localparam logic [1:0] MODE_CIRCLE = 2'd0;
    localparam logic [1:0] MODE_SQUARE = 2'd1;

    // Command function codes
    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_START = 1'b1;

    // Configuration register indexes
    localparam logic [2:0] REG_MODE   = 3'd0;
    localparam logic [2:0] REG_RADIUS = 3'd1;
    localparam logic [2:0] REG_RATE   = 3'd2;
    localparam logic [2:0] REG_SIDE   = 3'd3;
    localparam logic [2:0] REG_HOLD_X = 3'd4;
    localparam logic [2:0] REG_HOLD_Y = 3'd5;
    localparam logic [2:0] REG_HOLD_Z = 3'd6;
    localparam logic [2:0] REG_TICK   = 3'd7;

    // One command item
    typedef struct packed {
        logic               func;
        logic signed [31:0] cur_x;
        logic signed [31:0] cur_y;
        logic signed [31:0] cur_z;
    } cmd_t;

    // One setpoint item
    typedef struct packed {
        logic signed [31:0] set_x;
        logic signed [31:0] set_y;
        logic signed [31:0] set_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] acc_x;
        logic signed [31:0] acc_y;
        logic [15:0]        heading;
        logic signed [31:0] heading_rate;
    } setpoint_t;

    // Arctangent of 2^-i as a Q0.32 binary angle, full turn is 2^32
    function automatic logic [31:0] atan_entry(input logic [STEP_W-1:0] idx);
        logic [31:0] val;
        case (idx)
            5'd0:    val = 32'h2000_0000;
            5'd1:    val = 32'h12E4_051E;
            5'd2:    val = 32'h09FB_385B;
            5'd3:    val = 32'h0511_11D4;
            5'd4:    val = 32'h028B_0D43;
            5'd5:    val = 32'h0145_D7E1;
            5'd6:    val = 32'h00A2_F61E;
            5'd7:    val = 32'h0051_7C55;
            5'd8:    val = 32'h0028_BE53;
            5'd9:    val = 32'h0014_5F2F;
            5'd10:   val = 32'h000A_2F98;
            5'd11:   val = 32'h0005_17CC;
            5'd12:   val = 32'h0002_8BE6;
            5'd13:   val = 32'h0001_45F3;
            5'd14:   val = 32'h0000_A2FA;
            5'd15:   val = 32'h0000_517D;
            5'd16:   val = 32'h0000_28BE;
            5'd17:   val = 32'h0000_145F;
            5'd18:   val = 32'h0000_0A30;
            5'd19:   val = 32'h0000_0518;
            5'd20:   val = 32'h0000_028C;
            5'd21:   val = 32'h0000_0146;
            5'd22:   val = 32'h0000_00A3;
            5'd23:   val = 32'h0000_0051;
            default: val = 32'h0000_0000;
        endcase
        return val;
    endfunction

    // Sign extension of a 32-bit value to the wide width
    function automatic logic signed [SW-1:0] sext32(input logic signed [31:0] v);
        return {{(SW-32){v[31]}}, v};
    endfunction

    // Clamp a wide signed value to the 32-bit signed range
    function automatic logic signed [31:0] sat32(input logic signed [SW-1:0] v);
        logic signed [31:0] res;
        if (v[SW-1:31] == '0 || v[SW-1:31] == '1) begin
            res = v[31:0];
        end
        else if (v[SW-1]) begin
            res = 32'sh8000_0000;
        end
        else begin
            res = 32'sh7FFF_FFFF;
        end
        return res;
    endfunction

endpackage

FILE: rtl/rtg_if.sv
interface rtg_if #(parameter type T = logic);

    logic valid;
    logic ready;
    T     data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);

endinterface

FILE: rtl/rtg_mul.sv
module rtg_mul
    import rtg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic signed [OPW-1:0] mcand,
    input  logic signed [OPW-1:0] mplier,
    output logic                  done,
    output logic signed [PW-1:0]  product
);

    localparam int unsigned CW = $clog2(OPW);

    logic signed [OPW:0]   hi_reg, hi_next;
    logic [OPW-1:0]        lo_reg, lo_next;
    logic signed [OPW-1:0] mc_reg, mc_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic                  run_reg, run_next;
    logic                  done_reg, done_next;
    logic                  last;
    logic signed [OPW+1:0] addend;
    logic signed [OPW+1:0] sum;

    // One multiplier bit per cycle; the sign bit is weighted negatively.
    always_comb
    begin
        last   = (cnt_reg == CW'(OPW - 1));
        addend = {{2{mc_reg[OPW-1]}}, mc_reg};
        if (last)
        begin
            addend = -addend;
        end
        if (!lo_reg[0])
        begin
            addend = '0;
        end
        sum = {hi_reg[OPW], hi_reg} + addend;

        hi_next   = hi_reg;
        lo_next   = lo_reg;
        mc_next   = mc_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            hi_next  = '0;
            lo_next  = mplier;
            mc_next  = mcand;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            hi_next  = sum[OPW+1:1];
            lo_next  = {sum[0], lo_reg[OPW-1:1]};
            cnt_next = cnt_reg + CW'(1);
            if (last)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        hi_reg <= hi_next;
        lo_reg <= lo_next;
        mc_reg <= mc_next;
    end

    assign done    = done_reg;
    assign product = {hi_reg, lo_reg};

endmodule

FILE: rtl/rtg_cordic.sv
module rtg_cordic
    import rtg_pkg::*;
#(
    parameter int unsigned CORDIC_STEPS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [31:0]        angle,
    output logic               done,
    output logic signed [33:0] cos_val,
    output logic signed [33:0] sin_val
);

    logic signed [33:0]  x_reg, x_next;
    logic signed [33:0]  y_reg, y_next;
    logic signed [32:0]  z_reg, z_next;
    logic [STEP_W-1:0]   i_reg, i_next;
    logic                flip_reg, flip_next;
    logic                run_reg, run_next;
    logic                done_reg, done_next;
    logic [31:0]         rot;
    logic [31:0]         red;
    logic signed [33:0]  dx;
    logic signed [33:0]  dy;
    logic signed [32:0]  tab;

    // Range reduction on start, then one rotation step per cycle.
    always_comb
    begin
        rot = angle + QUARTER_TURN;
        red = rot[31] ? (angle + HALF_TURN) : angle;
        dx  = y_reg >>> i_reg;
        dy  = x_reg >>> i_reg;
        tab = {1'b0, atan_entry(i_reg)};

        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        i_next    = i_reg;
        flip_next = flip_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            flip_next = rot[31];
            z_next    = {red[31], red};
            x_next    = CORDIC_GAIN;
            y_next    = '0;
            i_next    = '0;
            run_next  = 1'b1;
        end
        else if (run_reg)
        begin
            if (!z_reg[32])
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - tab;
            end
            else
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + tab;
            end
            i_next = i_reg + STEP_W'(1);
            if (i_reg == STEP_W'(CORDIC_STEPS - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            i_reg    <= i_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        flip_reg <= flip_next;
    end

    assign done    = done_reg;
    assign cos_val = flip_reg ? -x_reg : x_reg;
    assign sin_val = flip_reg ? -y_reg : y_reg;

endmodule

FILE: rtl/reference_trajectory_generator_top.sv
// Circle, square and hover setpoint generator.
// Command items arrive on cmd (valid/ready); a start item captures the current
// position as centre and height, arms the block and clears both phases. Every
// tick item after that gives one setpoint item on setpoint (valid/ready).
// Ticks before the first start give no item. Registers are written through
// wr_en, wr_index and wr_data, only while the block is idle; the block itself
// does not enforce this, the user must. A tick runs four products on a shared
// bit-serial multiplier, then wraps and clamps the walked distance; hover mode
// then finishes, and square mode first finds the edge and the point on it.
// Circle mode instead runs the CORDIC and eight more products.
// cmd is ready only between ticks; one item is in work at a time.
// The finished setpoint sits in an output register, so the next command can
// be taken while the receiver stalls; a new setpoint waits in the last stage
// until that register is free.
// Reset clears the registers to their defaults and disarms the block.
module reference_trajectory_generator_top
    import rtg_pkg::*;
#(
    parameter int unsigned FRAC_BITS    = 16,
    parameter int unsigned CORDIC_STEPS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  logic [2:0]  wr_index,
    input  logic [31:0] wr_data,
    rtg_if.sink         cmd,
    rtg_if.source       setpoint
);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_MUL    = 8'b0000_0010,
        ST_WRAP   = 8'b0000_0100,
        ST_CLAMP  = 8'b0000_1000,
        ST_CORDIC = 8'b0001_0000,
        ST_SEG    = 8'b0010_0000,
        ST_SQUARE = 8'b0100_0000,
        ST_FINISH = 8'b1000_0000
    } state_t;

    typedef enum logic [3:0] {
        OP_RT, OP_ANG, OP_V, OP_DS, OP_RW, OP_RWW,
        OP_XC, OP_YS, OP_VX, OP_VY, OP_AX, OP_AY
    } op_t;

    localparam logic [15:0] HDG_SIDE0 = 16'd16384;
    localparam logic [15:0] HDG_SIDE1 = 16'd32768;
    localparam logic [15:0] HDG_SIDE2 = 16'd49152;
    localparam logic [15:0] HDG_SIDE3 = 16'd0;

    // Configuration registers
    logic [1:0]         mode_reg;
    logic [30:0]        radius_reg;
    logic signed [31:0] rate_reg;
    logic [30:0]        side_reg;
    logic signed [31:0] hold_x_reg;
    logic signed [31:0] hold_y_reg;
    logic signed [31:0] hold_z_reg;
    logic [15:0]        tick_reg;

    // Trajectory state
    state_t             state_reg, state_next;
    op_t                op_reg, op_next;
    logic               mul_go_reg, mul_go_next;
    logic               cor_go_reg, cor_go_next;
    logic               armed_reg, armed_next;
    logic [31:0]        angle_reg, angle_next;
    logic [31:0]        path_reg, path_next;
    logic signed [31:0] cx_reg, cx_next;
    logic signed [31:0] cy_reg, cy_next;
    logic signed [31:0] height_reg, height_next;

    // Working values of one tick
    logic signed [31:0] step_reg, step_next;
    logic signed [31:0] v_reg, v_next;
    logic signed [31:0] rw_reg, rw_next;
    logic signed [31:0] rww_reg, rww_next;
    logic signed [34:0] d_reg, d_next;
    logic [1:0]         seg_reg, seg_next;
    logic [30:0]        ph_reg, ph_next;
    setpoint_t          res_reg, res_next;
    setpoint_t          out_reg, out_next;
    logic               out_valid_reg, out_valid_next;

    // Shared units
    logic signed [OPW-1:0] mul_a;
    logic signed [OPW-1:0] mul_b;
    logic                  mul_done;
    logic signed [PW-1:0]  prod;
    logic                  cor_done;
    logic signed [33:0]    cos_val;
    logic signed [33:0]    sin_val;
    logic signed [33:0]    ncos;
    logic signed [33:0]    nsin;

    // Combinational helpers
    logic                  cmd_fire;
    logic signed [SW-1:0]  prod_w;
    logic signed [SW-1:0]  prod_f;
    logic signed [SW-1:0]  prod_f1;
    logic signed [SW-1:0]  prod_30;
    logic signed [34:0]    perim;
    logic [31:0]           hdg_full;
    logic [32:0]           s1;
    logic [32:0]           s2;
    logic [32:0]           s3;
    logic [32:0]           ph33;
    logic [32:0]           diff;
    logic signed [35:0]    cx2;
    logic signed [35:0]    cy2;
    logic signed [35:0]    side36;
    logic signed [35:0]    ph2;
    logic signed [35:0]    xs;
    logic signed [35:0]    ys;
    logic signed [SW-1:0]  xs_w;
    logic signed [SW-1:0]  ys_w;

    rtg_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_go_reg),
        .mcand   (mul_a),
        .mplier  (mul_b),
        .done    (mul_done),
        .product (prod)
    );

    rtg_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cor_go_reg),
        .angle   (angle_reg),
        .done    (cor_done),
        .cos_val (cos_val),
        .sin_val (sin_val)
    );

    assign ncos = -cos_val;
    assign nsin = -sin_val;

    // Operand selection for the shared multiplier
    always_comb
    begin
        case (op_reg)
            OP_RT:
            begin
                mul_a = {rate_reg[31], rate_reg};
                mul_b = {17'b0, tick_reg};
            end
            OP_ANG:
            begin
                mul_a = {step_reg[31], step_reg};
                mul_b = {1'b0, INV_TWO_PI};
            end
            OP_V:
            begin
                mul_a = {rate_reg[31], rate_reg};
                mul_b = {2'b0, side_reg};
            end
            OP_DS:
            begin
                mul_a = {v_reg[31], v_reg};
                mul_b = {17'b0, tick_reg};
            end
            OP_RW:
            begin
                mul_a = {2'b0, radius_reg};
                mul_b = {rate_reg[31], rate_reg};
            end
            OP_RWW:
            begin
                mul_a = {rw_reg[31], rw_reg};
                mul_b = {rate_reg[31], rate_reg};
            end
            OP_XC:
            begin
                mul_a = {2'b0, radius_reg};
                mul_b = cos_val[OPW-1:0];
            end
            OP_YS:
            begin
                mul_a = {2'b0, radius_reg};
                mul_b = sin_val[OPW-1:0];
            end
            OP_VX:
            begin
                mul_a = {rw_reg[31], rw_reg};
                mul_b = nsin[OPW-1:0];
            end
            OP_VY:
            begin
                mul_a = {rw_reg[31], rw_reg};
                mul_b = cos_val[OPW-1:0];
            end
            OP_AX:
            begin
                mul_a = {rww_reg[31], rww_reg};
                mul_b = ncos[OPW-1:0];
            end
            OP_AY:
            begin
                mul_a = {rww_reg[31], rww_reg};
                mul_b = nsin[OPW-1:0];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Shifted views of the product and the square geometry
    always_comb
    begin
        prod_w   = {prod[PW-1], prod};
        prod_f   = prod_w >>> FRAC_BITS;
        prod_f1  = prod_w >>> (FRAC_BITS + 1);
        prod_30  = prod_w >>> 30;
        perim    = $signed({2'b0, side_reg, 2'b00});
        hdg_full = angle_reg + HALF_TURN;

        s1   = {2'b0, side_reg};
        s2   = {1'b0, side_reg, 1'b0};
        s3   = s1 + s2;
        ph33 = {1'b0, path_reg};
        if (ph33 < s1)
        begin
            diff = ph33;
        end
        else if (ph33 < s2)
        begin
            diff = ph33 - s1;
        end
        else if (ph33 < s3)
        begin
            diff = ph33 - s2;
        end
        else
        begin
            diff = ph33 - s3;
        end

        cx2    = {{3{cx_reg[31]}}, cx_reg, 1'b0};
        cy2    = {{3{cy_reg[31]}}, cy_reg, 1'b0};
        side36 = $signed({5'b0, side_reg});
        ph2    = $signed({4'b0, ph_reg, 1'b0});
        case (seg_reg)
            2'd0:
            begin
                xs = cx2 + side36;
                ys = cy2 - side36 + ph2;
            end
            2'd1:
            begin
                xs = cx2 + side36 - ph2;
                ys = cy2 + side36;
            end
            2'd2:
            begin
                xs = cx2 - side36;
                ys = cy2 + side36 - ph2;
            end
            default:
            begin
                xs = cx2 - side36 + ph2;
                ys = cy2 - side36;
            end
        endcase
        xs_w = $signed({{(SW-36){xs[35]}}, xs}) >>> 1;
        ys_w = $signed({{(SW-36){ys[35]}}, ys}) >>> 1;
    end

    assign cmd_fire = cmd.valid && cmd.ready;

    // Sequencer and datapath next state
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        mul_go_next    = 1'b0;
        cor_go_next    = 1'b0;
        armed_next     = armed_reg;
        angle_next     = angle_reg;
        path_next      = path_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        height_next    = height_reg;
        step_next      = step_reg;
        v_next         = v_reg;
        rw_next        = rw_reg;
        rww_next       = rww_reg;
        d_next         = d_reg;
        seg_next       = seg_reg;
        ph_next        = ph_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !setpoint.ready;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    if (cmd.data.func == FUNC_START)
                    begin
                        cx_next     = cmd.data.cur_x;
                        cy_next     = cmd.data.cur_y;
                        height_next = cmd.data.cur_z;
                        armed_next  = 1'b1;
                        angle_next  = '0;
                        path_next   = '0;
                    end
                    else if (armed_reg)
                    begin
                        res_next    = '0;
                        op_next     = OP_RT;
                        mul_go_next = 1'b1;
                        state_next  = ST_MUL;
                    end
                end
            end

            // Store each finished product and launch the next one, if any.
            ST_MUL:
            begin
                if (mul_done)
                begin
                    mul_go_next = 1'b1;
                    case (op_reg)
                        OP_RT:
                        begin
                            step_next = prod[47:16];
                            op_next   = OP_ANG;
                        end
                        OP_ANG:
                        begin
                            angle_next = angle_reg + prod[FRAC_BITS+31 -: 32];
                            op_next    = OP_V;
                        end
                        OP_V:
                        begin
                            v_next  = sat32(prod_f1);
                            op_next = OP_DS;
                        end
                        OP_DS:
                        begin
                            d_next      = $signed({3'b0, path_reg})
                                        + {{3{prod[47]}}, prod[47:16]};
                            mul_go_next = 1'b0;
                            state_next  = ST_WRAP;
                        end
                        OP_RW:
                        begin
                            rw_next = sat32(prod_f);
                            op_next = OP_RWW;
                        end
                        OP_RWW:
                        begin
                            rww_next = sat32(prod_f);
                            op_next  = OP_XC;
                        end
                        OP_XC:
                        begin
                            res_next.set_x = sat32(prod_30 + sext32(cx_reg));
                            op_next        = OP_YS;
                        end
                        OP_YS:
                        begin
                            res_next.set_y = sat32(prod_30 + sext32(cy_reg));
                            op_next        = OP_VX;
                        end
                        OP_VX:
                        begin
                            res_next.vel_x = sat32(prod_30);
                            op_next        = OP_VY;
                        end
                        OP_VY:
                        begin
                            res_next.vel_y = sat32(prod_30);
                            op_next        = OP_AX;
                        end
                        OP_AX:
                        begin
                            res_next.acc_x = sat32(prod_30);
                            op_next        = OP_AY;
                        end
                        OP_AY:
                        begin
                            res_next.acc_y = sat32(prod_30);
                            mul_go_next    = 1'b0;
                            state_next     = ST_FINISH;
                        end
                        default:
                        begin
                            mul_go_next = 1'b0;
                            state_next  = ST_IDLE;
                        end
                    endcase
                end
            end

            // At most one perimeter subtraction or addition.
            ST_WRAP:
            begin
                if (d_reg >= perim)
                begin
                    d_next = d_reg - perim;
                end
                else if (d_reg < 0)
                begin
                    d_next = d_reg + perim;
                end
                state_next = ST_CLAMP;
            end

            // Restart the walk when the distance is still out of range, then branch on the mode.
            ST_CLAMP:
            begin
                if (d_reg[34] || d_reg >= perim || d_reg[33:32] != 2'b00)
                begin
                    path_next = '0;
                end
                else
                begin
                    path_next = d_reg[31:0];
                end
                if (mode_reg == MODE_CIRCLE)
                begin
                    res_next.set_z        = height_reg;
                    res_next.heading      = hdg_full[31:16];
                    res_next.heading_rate = rate_reg;
                    cor_go_next           = 1'b1;
                    state_next            = ST_CORDIC;
                end
                else if (mode_reg == MODE_SQUARE)
                begin
                    state_next = ST_SEG;
                end
                else
                begin
                    res_next.set_x = hold_x_reg;
                    res_next.set_y = hold_y_reg;
                    res_next.set_z = hold_z_reg;
                    state_next     = ST_FINISH;
                end
            end

            ST_CORDIC:
            begin
                if (cor_done)
                begin
                    op_next     = OP_RW;
                    mul_go_next = 1'b1;
                    state_next  = ST_MUL;
                end
            end

            // Find the edge of the square and the distance along it.
            ST_SEG:
            begin
                if (ph33 < s1)
                begin
                    seg_next = 2'd0;
                end
                else if (ph33 < s2)
                begin
                    seg_next = 2'd1;
                end
                else if (ph33 < s3)
                begin
                    seg_next = 2'd2;
                end
                else
                begin
                    seg_next = 2'd3;
                end
                ph_next    = diff[30:0];
                state_next = ST_SQUARE;
            end

            ST_SQUARE:
            begin
                res_next.set_x = sat32(xs_w);
                res_next.set_y = sat32(ys_w);
                res_next.set_z = height_reg;
                case (seg_reg)
                    2'd0:
                    begin
                        res_next.vel_y   = v_reg;
                        res_next.heading = HDG_SIDE0;
                    end
                    2'd1:
                    begin
                        res_next.vel_x   = sat32(-sext32(v_reg));
                        res_next.heading = HDG_SIDE1;
                    end
                    2'd2:
                    begin
                        res_next.vel_y   = sat32(-sext32(v_reg));
                        res_next.heading = HDG_SIDE2;
                    end
                    default:
                    begin
                        res_next.vel_x   = v_reg;
                        res_next.heading = HDG_SIDE3;
                    end
                endcase
                state_next = ST_FINISH;
            end

            // Hand the setpoint to the output register once it is free.
            ST_FINISH:
            begin
                if (!out_valid_reg || setpoint.ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 2'd0;
            radius_reg <= 31'd32768;
            rate_reg   <= 32'sd19661;
            side_reg   <= 31'd262144;
            hold_x_reg <= '0;
            hold_y_reg <= '0;
            hold_z_reg <= 32'sd131072;
            tick_reg   <= 16'd3277;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_MODE:   mode_reg   <= wr_data[1:0];
                REG_RADIUS: radius_reg <= wr_data[30:0];
                REG_RATE:   rate_reg   <= wr_data;
                REG_SIDE:   side_reg   <= wr_data[30:0];
                REG_HOLD_X: hold_x_reg <= wr_data;
                REG_HOLD_Y: hold_y_reg <= wr_data;
                REG_HOLD_Z: hold_z_reg <= wr_data;
                REG_TICK:   tick_reg   <= wr_data[15:0];
                default:    mode_reg   <= mode_reg;
            endcase
        end
    end

    // Control and trajectory state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_RT;
            mul_go_reg    <= 1'b0;
            cor_go_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            armed_reg     <= 1'b0;
            angle_reg     <= '0;
            path_reg      <= '0;
            cx_reg        <= '0;
            cy_reg        <= '0;
            height_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            mul_go_reg    <= mul_go_next;
            cor_go_reg    <= cor_go_next;
            out_valid_reg <= out_valid_next;
            armed_reg     <= armed_next;
            angle_reg     <= angle_next;
            path_reg      <= path_next;
            cx_reg        <= cx_next;
            cy_reg        <= cy_next;
            height_reg    <= height_next;
        end
    end

    // Working payload registers
    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        v_reg    <= v_next;
        rw_reg   <= rw_next;
        rww_reg  <= rww_next;
        d_reg    <= d_next;
        seg_reg  <= seg_next;
        ph_reg   <= ph_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

    assign cmd.ready      = (state_reg == ST_IDLE);
    assign setpoint.valid = out_valid_reg;
    assign setpoint.data  = out_reg;

endmodule
